FILE: rtl/core/flc_pkg.sv
// Shared constants, types and helpers of the fader law codec.
package flc_pkg;

    // Fixed point formats of levels (dB) and of normalised fader travel.
    localparam int DB_FRACTION_BITS   = 8;
    localparam int NORM_FRACTION_BITS = 16;
    localparam int DB_ONE             = 1 << DB_FRACTION_BITS;
    localparam int NORM_ONE           = 1 << NORM_FRACTION_BITS;

    // Field and register widths.
    localparam int VALUE_W   = 20;
    localparam int FLOOR_W   = 17;
    localparam int CEIL_W    = 13;
    localparam int TOL_W     = 12;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    // Internal signed width for levels, clamps and differences.
    localparam int LEVEL_W = VALUE_W + 1;
    // Normalised travel, 0 up to and including 1.0.
    localparam int NORM_W  = NORM_FRACTION_BITS + 1;
    // Width of a result before it is saturated to the field.
    localparam int RES_W   = (NORM_W + 1 > LEVEL_W) ? NORM_W + 1 : LEVEL_W;

    localparam int FIELD_MAX = (1 << (VALUE_W - 1)) - 1;
    localparam int FIELD_MIN = -(1 << (VALUE_W - 1));

    // Segment breakpoints of the fader law in level units.
    localparam int DB_M90 = -90 * DB_ONE;
    localparam int DB_M60 = -60 * DB_ONE;
    localparam int DB_M30 = -30 * DB_ONE;
    localparam int DB_M10 = -10 * DB_ONE;

    // Register values after reset.
    localparam logic signed [FLOOR_W-1:0] FLOOR_RESET     = -17'sd23040;
    localparam logic [CEIL_W-1:0]         CEILING_RESET   = 13'd2560;
    localparam logic [TOL_W-1:0]          TOLERANCE_RESET = 12'd128;

    typedef enum logic [1:0] {
        OP_ENCODE  = 2'd0,
        OP_DECODE  = 2'd1,
        OP_COMPARE = 2'd2
    } t_operation;

    typedef enum logic [1:0] {
        ENC_DB   = 2'd0,
        ENC_NORM = 2'd1,
        ENC_FLAG = 2'd2
    } t_encoding;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOOR     = 2'd0,
        CFG_CEILING   = 2'd1,
        CFG_TOLERANCE = 2'd2
    } t_cfg_index;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic signed [FLOOR_W-1:0] floor_db;
        logic [CEIL_W-1:0]         ceiling_db;
        logic [TOL_W-1:0]          tolerance_db;
    } t_cfg;

    // Saturate a wide result to the signed output field.
    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [RES_W-1:0] r);
        logic signed [VALUE_W-1:0] s;
        if (r > $signed(RES_W'(FIELD_MAX))) begin
            s = VALUE_W'(FIELD_MAX);
        end else if (r < $signed(RES_W'(FIELD_MIN))) begin
            s = VALUE_W'(FIELD_MIN);
        end else begin
            s = VALUE_W'(r);
        end
        return s;
    endfunction

endpackage

FILE: rtl/core/flc_db_to_norm.sv
// Encoder from a clamped dB level to normalised fader travel.
module flc_db_to_norm import flc_pkg::*; (
    input  logic signed [LEVEL_W-1:0] i_level,
    output logic [NORM_W-1:0]         o_norm
);

    // Offset level within its segment; the ceiling bounds the top segment.
    localparam int X_W  = $clog2((1 << CEIL_W) + 40 * DB_ONE);
    // Numerator after the power of two part of the divisor is shifted out.
    localparam int V_W  = X_W + NORM_FRACTION_BITS - 3 - DB_FRACTION_BITS;
    // Reciprocal scaling for the remaining division by 5 or 15.
    localparam int K_W  = V_W + 4;
    localparam int M_W  = K_W - 2;
    localparam int P_W  = V_W + M_W;
    localparam int Q_W  = V_W - 2;
    localparam int SH_W = $clog2(DB_FRACTION_BITS + 6);
    localparam logic [M_W-1:0] M15 = M_W'(((64'd1 << K_W) + 64'd14) / 64'd15);
    localparam logic [M_W-1:0] M5  = M_W'(((64'd1 << K_W) + 64'd4) / 64'd5);

    logic signed [LEVEL_W-1:0]      offset;
    logic signed [LEVEL_W-1:0]      shifted_level;
    logic [SH_W-1:0]                shamt;
    logic [M_W-1:0]                 recip;
    logic [X_W-1:0]                 x;
    logic [X_W+NORM_FRACTION_BITS-1:0] num;
    logic [V_W-1:0]                 v;
    logic [P_W-1:0]                 prod;
    logic [Q_W-1:0]                 q;

    // Pick the segment: offset to its origin, divisor shift and reciprocal.
    always_comb begin
        if (i_level < DB_M60) begin
            offset = LEVEL_W'(90 * DB_ONE);
            shamt  = SH_W'(DB_FRACTION_BITS + 5);
            recip  = M15;
        end else if (i_level < DB_M30) begin
            offset = LEVEL_W'(70 * DB_ONE);
            shamt  = SH_W'(DB_FRACTION_BITS + 5);
            recip  = M5;
        end else if (i_level < DB_M10) begin
            offset = LEVEL_W'(50 * DB_ONE);
            shamt  = SH_W'(DB_FRACTION_BITS + 4);
            recip  = M5;
        end else begin
            offset = LEVEL_W'(30 * DB_ONE);
            shamt  = SH_W'(DB_FRACTION_BITS + 3);
            recip  = M5;
        end
    end

    // Positive numerator, divided by a power of two and then by 5 or 15.
    assign shifted_level = i_level + offset;
    assign x    = shifted_level[X_W-1:0];
    assign num  = {x, NORM_FRACTION_BITS'(0)};
    assign v    = V_W'(num >> shamt);
    assign prod = P_W'(v) * P_W'(recip);
    assign q    = Q_W'(prod >> K_W);

    // Silent below the law's bottom, limited to full travel at the top.
    always_comb begin
        if (i_level <= DB_M90) begin
            o_norm = '0;
        end else if (q > Q_W'(NORM_ONE)) begin
            o_norm = NORM_W'(NORM_ONE);
        end else begin
            o_norm = NORM_W'(q);
        end
    end

endmodule

FILE: rtl/core/flc_norm_to_db.sv
// Decoder from normalised fader travel to a dB level.
module flc_norm_to_db import flc_pkg::*; (
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_cfg                      i_cfg,
    output logic signed [LEVEL_W-1:0] o_level
);

    localparam int CMP_W = ((VALUE_W > NORM_W) ? VALUE_W : NORM_W) + 1;
    localparam int P_W   = NORM_W + 9 + DB_FRACTION_BITS;
    localparam int S_W   = P_W - NORM_FRACTION_BITS;

    logic signed [CMP_W-1:0]   a_ext;
    logic [NORM_W-1:0]         trav;
    logic [P_W-1:0]            t5;
    logic [P_W-1:0]            t15;
    logic [P_W-1:0]            prod;
    logic [S_W-1:0]            scaled;
    logic signed [LEVEL_W-1:0] offset;
    logic signed [LEVEL_W-1:0] level;

    // Travel above 1.0 is taken as 1.0.
    assign a_ext = CMP_W'(i_value);
    assign trav  = (a_ext > $signed(CMP_W'(NORM_ONE))) ? NORM_W'(NORM_ONE) : NORM_W'(a_ext);

    // Constant multiples of the travel by shift and add.
    assign t5  = (P_W'(trav) << 2) + P_W'(trav);
    assign t15 = (P_W'(trav) << 4) - P_W'(trav);

    // Segment slope in dB per full travel, and the segment's dB origin.
    always_comb begin
        if (trav >= NORM_W'(NORM_ONE / 2)) begin
            prod   = t5 << (DB_FRACTION_BITS + 3);
            offset = LEVEL_W'(30 * DB_ONE);
        end else if (trav >= NORM_W'(NORM_ONE / 4)) begin
            prod   = t5 << (DB_FRACTION_BITS + 4);
            offset = LEVEL_W'(50 * DB_ONE);
        end else if (trav >= NORM_W'(NORM_ONE / 16)) begin
            prod   = t5 << (DB_FRACTION_BITS + 5);
            offset = LEVEL_W'(70 * DB_ONE);
        end else begin
            prod   = t15 << (DB_FRACTION_BITS + 5);
            offset = LEVEL_W'(90 * DB_ONE);
        end
    end

    assign scaled = S_W'(prod >> NORM_FRACTION_BITS);
    assign level  = $signed(LEVEL_W'(scaled)) - offset;

    // Zero or negative travel means the floor.
    assign o_level = (a_ext <= 0) ? LEVEL_W'(i_cfg.floor_db) : level;

endmodule

FILE: rtl/core/flc_compare.sv
// Agreement check between a commanded and a read-back dB level.
module flc_compare import flc_pkg::*; (
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic signed [VALUE_W-1:0] i_second_value,
    input  t_cfg                      i_cfg,
    output logic                      o_agrees
);

    logic signed [LEVEL_W-1:0] a;
    logic signed [LEVEL_W-1:0] b;
    logic signed [LEVEL_W-1:0] lim;
    logic signed [LEVEL_W-1:0] diff;
    logic signed [LEVEL_W-1:0] mag;
    logic                      both_silent;
    logic                      close;

    assign a   = LEVEL_W'(i_value);
    assign b   = LEVEL_W'(i_second_value);
    assign lim = LEVEL_W'(i_cfg.floor_db) + LEVEL_W'(DB_ONE / 2);

    // Both levels near the floor count as the same silent level.
    assign both_silent = (a <= lim) && (b <= lim);

    // Otherwise the absolute difference must stay within the tolerance.
    assign diff  = a - b;
    assign mag   = (diff < 0) ? -diff : diff;
    assign close = mag <= $signed(LEVEL_W'(i_cfg.tolerance_db));

    assign o_agrees = both_silent || close;

endmodule

FILE: rtl/core/fader_law_codec_top.sv
// Top level of the fader law codec: registers, handshakes and result selection.
// The codec takes one word per clock unless stalled and returns one result word for every
// word it takes, in order, via the input and then the result register. Sustained
// throughput is one word per cycle without output stalls, set by the single pass of logic
// between those two registers, whose longest path is one 20 by 22 bit multiplication by
// a reciprocal constant in the dB to normalised encoder. A word is taken while an earlier
// result waits on a stalled output, if the input register has room. Configuration writes
// take effect at the next edge and must only be made while no word is in flight.
module fader_law_codec_top import flc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // Input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_operation,
    input  logic [1:0]                i_encoding,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic signed [VALUE_W-1:0] i_second_value,
    // Output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic                      o_agrees
);

    t_cfg                      r_cfg;
    logic                      r_s1_valid;
    logic [1:0]                r_operation;
    logic [1:0]                r_encoding;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_second_value;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_result_value;
    logic                      r_agrees;

    logic                      out_free;
    logic                      s1_take;
    logic signed [LEVEL_W-1:0] level_in;
    logic signed [LEVEL_W-1:0] floor_l;
    logic signed [LEVEL_W-1:0] ceil_l;
    logic signed [LEVEL_W-1:0] raised;
    logic signed [LEVEL_W-1:0] clamped;
    logic [NORM_W-1:0]         enc_norm;
    logic signed [LEVEL_W-1:0] dec_level;
    logic                      cmp_agrees;
    logic signed [RES_W-1:0]   n_wide;
    logic signed [VALUE_W-1:0] n_result_value;
    logic                      n_agrees;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_db     <= FLOOR_RESET;
            r_cfg.ceiling_db   <= CEILING_RESET;
            r_cfg.tolerance_db <= TOLERANCE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FLOOR:     r_cfg.floor_db     <= i_cfg_data[FLOOR_W-1:0];
                CFG_CEILING:   r_cfg.ceiling_db   <= i_cfg_data[CEIL_W-1:0];
                CFG_TOLERANCE: r_cfg.tolerance_db <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: the result register frees up when empty or taken.
    assign out_free = !r_out_valid || !i_stall;
    assign s1_take  = !r_s1_valid || out_free;
    assign o_stall  = !s1_take;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_take) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && i_valid) begin
            r_operation    <= i_operation;
            r_encoding     <= i_encoding;
            r_value        <= i_value;
            r_second_value <= i_second_value;
        end
    end

    // Clamp the level to the floor first, then to the ceiling.
    assign level_in = LEVEL_W'(r_value);
    assign floor_l  = LEVEL_W'(r_cfg.floor_db);
    assign ceil_l   = $signed(LEVEL_W'(r_cfg.ceiling_db));
    assign raised   = (level_in < floor_l) ? floor_l : level_in;
    assign clamped  = (raised > ceil_l) ? ceil_l : raised;

    flc_db_to_norm u_db_to_norm (
        .i_level (clamped),
        .o_norm  (enc_norm)
    );

    flc_norm_to_db u_norm_to_db (
        .i_value (r_value),
        .i_cfg   (r_cfg),
        .o_level (dec_level)
    );

    flc_compare u_compare (
        .i_value        (r_value),
        .i_second_value (r_second_value),
        .i_cfg          (r_cfg),
        .o_agrees       (cmp_agrees)
    );

    // Select the result by operation and wire form; unused forms act as dB.
    always_comb begin
        n_wide   = '0;
        n_agrees = 1'b0;
        unique case (t_operation'(r_operation))
            OP_ENCODE: begin
                case (t_encoding'(r_encoding))
                    ENC_NORM: n_wide = RES_W'(enc_norm);
                    ENC_FLAG: n_wide = (clamped > floor_l) ? RES_W'(1) : '0;
                    default:  n_wide = RES_W'(clamped);
                endcase
            end
            OP_DECODE: begin
                case (t_encoding'(r_encoding))
                    ENC_NORM: n_wide = RES_W'(dec_level);
                    ENC_FLAG: n_wide = (r_value >= 1) ? '0 : RES_W'(floor_l);
                    default:  n_wide = RES_W'(clamped);
                endcase
            end
            OP_COMPARE: begin
                n_agrees = cmp_agrees;
            end
            default: ;
        endcase
    end

    assign n_result_value = sat_value(n_wide);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_result_value <= n_result_value;
            r_agrees       <= n_agrees;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_result_value;
    assign o_agrees       = r_agrees;

`ifndef SYNTHESIS
    // Only a compare reports agreement, and a compare carries a zero value.
    a_agree_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_agrees |-> o_result_value == '0)
        else $error("agreement reported with a nonzero result value");

    // The input is stalled only when both registers hold words and the output is stalled.
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_out_valid && i_stall)
        else $error("input stalled while the pipeline has room");

    // A full, stalled pipeline keeps both of its words.
    a_hold_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && i_stall |=> r_s1_valid && r_out_valid)
        else $error("word lost while the output was stalled");

    // A taken result with nothing behind it leaves the output empty.
    a_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_stall && !r_s1_valid |=> !r_out_valid)
        else $error("result repeated after it was taken");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the four-segment fader law codec: directed and random words.
module tb_top import flc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package enums leave unnamed but the ports can carry.
    localparam logic [1:0] OP_RESERVED  = 2'b11;
    localparam logic [1:0] ENC_RESERVED = 2'b11;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER_WORDS = 400;
    localparam int HOLD_CYCLES = 400;
    localparam int WORDS_PER_PHASE = 200;
    localparam int PHASES = 7;
    localparam int MAX_REPORTS = 10;

    // Segment breakpoints and the top of the law, in level units.
    localparam int BREAKPOINTS [5] = '{DB_M90, DB_M60, DB_M30, DB_M10, 10 * DB_ONE};
    localparam int TRAVEL_POINTS [5] = '{0, NORM_ONE / 16, NORM_ONE / 4, NORM_ONE / 2,
                                         NORM_ONE};

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // One result word as the block returns it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] level;
        logic                      agrees;
    } t_fader_word;

    // Fader law predictor with its own register copy and the queue of expected words.
    class fader_scoreboard;
        int          floor_level;
        int          ceiling_level;
        int          tolerance_level;
        t_fader_word expected_words[$];
        int          failures;

        function new();
            floor_level = int'(FLOOR_RESET);
            ceiling_level = int'(CEILING_RESET);
            tolerance_level = int'(TOLERANCE_RESET);
            failures = 0;
        endfunction

        function void write_register(t_cfg_index idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_FLOOR: floor_level = int'($signed(data[FLOOR_W-1:0]));
                CFG_CEILING: ceiling_level = int'(data[CEIL_W-1:0]);
                CFG_TOLERANCE: tolerance_level = int'(data[TOL_W-1:0]);
                default: ;
            endcase
        endfunction

        // The floor is applied first, so the ceiling wins when they cross.
        function longint clamp_level(longint lvl);
            longint c;
            c = lvl;
            if (c < floor_level) c = floor_level;
            if (c > ceiling_level) c = ceiling_level;
            return c;
        endfunction

        function longint level_to_travel(longint lvl);
            longint n;
            if (lvl <= DB_M90) return 0;
            if (lvl < DB_M60) begin
                n = ((lvl + 90 * DB_ONE) * NORM_ONE) / (480 * DB_ONE);
            end else if (lvl < DB_M30) begin
                n = ((lvl + 70 * DB_ONE) * NORM_ONE) / (160 * DB_ONE);
            end else if (lvl < DB_M10) begin
                n = ((lvl + 50 * DB_ONE) * NORM_ONE) / (80 * DB_ONE);
            end else begin
                n = ((lvl + 30 * DB_ONE) * NORM_ONE) / (40 * DB_ONE);
            end
            if (n < 0) n = 0;
            if (n > NORM_ONE) n = NORM_ONE;
            return n;
        endfunction

        // Travel past full scale is read as full scale; the result is not clamped.
        function longint travel_to_level(longint travel);
            longint n;
            if (travel <= 0) return floor_level;
            n = (travel > NORM_ONE) ? NORM_ONE : travel;
            if (n >= NORM_ONE / 2) return (n * 40 * DB_ONE) / NORM_ONE - 30 * DB_ONE;
            if (n >= NORM_ONE / 4) return (n * 80 * DB_ONE) / NORM_ONE - 50 * DB_ONE;
            if (n >= NORM_ONE / 16) return (n * 160 * DB_ONE) / NORM_ONE - 70 * DB_ONE;
            return (n * 480 * DB_ONE) / NORM_ONE - 90 * DB_ONE;
        endfunction

        function t_fader_word convert(logic [1:0] op, logic [1:0] enc,
                                      logic signed [VALUE_W-1:0] commanded,
                                      logic signed [VALUE_W-1:0] readback);
            longint      a;
            longint      b;
            longint      r;
            longint      diff;
            t_fader_word w;
            a = longint'(commanded);
            b = longint'(readback);
            r = 0;
            w.agrees = 1'b0;
            case (op)
                OP_ENCODE: begin
                    case (enc)
                        ENC_NORM: r = level_to_travel(clamp_level(a));
                        ENC_FLAG: r = (clamp_level(a) > floor_level) ? 1 : 0;
                        default: r = clamp_level(a);
                    endcase
                end
                OP_DECODE: begin
                    case (enc)
                        ENC_NORM: r = travel_to_level(a);
                        ENC_FLAG: r = (a >= 1) ? 0 : floor_level;
                        default: r = clamp_level(a);
                    endcase
                end
                OP_COMPARE: begin
                    // Two levels near the floor agree whatever their difference.
                    diff = (a > b) ? a - b : b - a;
                    if (a <= floor_level + DB_ONE / 2 && b <= floor_level + DB_ONE / 2) begin
                        w.agrees = 1'b1;
                    end else if (diff <= tolerance_level) begin
                        w.agrees = 1'b1;
                    end
                end
                default: ;
            endcase
            if (r > FIELD_MAX) r = FIELD_MAX;
            if (r < FIELD_MIN) r = FIELD_MIN;
            w.level = r[VALUE_W-1:0];
            return w;
        endfunction

        function void note_word(logic [1:0] op, logic [1:0] enc,
                                logic signed [VALUE_W-1:0] commanded,
                                logic signed [VALUE_W-1:0] readback);
            expected_words.push_back(convert(op, enc, commanded, readback));
        endfunction

        function void check_word(logic signed [VALUE_W-1:0] level, logic agrees);
            t_fader_word want;
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("unexpected result word: level %0d agrees %0b", level, agrees);
                end
                return;
            end
            want = expected_words.pop_front();
            if (want.level !== level || want.agrees !== agrees) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("mismatch: expected level %0d agrees %0b, got level %0d agrees %0b",
                             want.level, want.agrees, level, agrees);
                end
            end
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction

        function void close();
            if (expected_words.size() != 0) begin
                failures++;
                $display("%0d expected result words never arrived", expected_words.size());
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [1:0]                i_operation = '0;
    logic [1:0]                i_encoding = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic signed [VALUE_W-1:0] i_second_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [VALUE_W-1:0] o_result_value;
    logic                      o_agrees;

    fader_scoreboard sb = new();
    int              accepted_words = 0;
    int              burst_left = 0;
    int unsigned     cycle_count = 0;

    fader_law_codec_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_encoding     (i_encoding),
        .i_value        (i_value),
        .i_second_value (i_second_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_agrees       (o_agrees)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Both handshakes are sampled at the edge with the values from before it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_word(i_operation, i_encoding, i_value, i_second_value);
                accepted_words++;
            end
            if (o_valid && !i_stall) begin
                sb.check_word(o_result_value, o_agrees);
            end
        end
    end

    // Receiver stalls in segments of differing density, with one long hold-off.
    initial begin : stall_pattern
        int          seg_len;
        int          period;
        bit          hold_done;
        t_stall_mode mode;
        hold_done = 1'b0;
        forever begin
            seg_len = $urandom_range(20, 300);
            period = $urandom_range(2, 6);
            mode = t_stall_mode'($urandom_range(0, 3));
            for (int k = 0; k < seg_len; k++) begin
                @(posedge i_clk);
                if (!hold_done && accepted_words >= HOLD_AFTER_WORDS) begin
                    hold_done = 1'b1;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    STALL_NONE: i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= (k % period == 0);
                endcase
            end
        end
    end

    // Offer one word and hold it until taken; bursts end in a gap with no word offered.
    task automatic send_word(logic [1:0] op, logic [1:0] enc, int commanded, int readback);
        i_operation <= op;
        i_encoding <= enc;
        i_value <= VALUE_W'(commanded);
        i_second_value <= VALUE_W'(readback);
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 120 : $urandom_range(1, 16);
        end
    endtask

    // Write all three registers on consecutive edges and mirror them.
    task automatic apply_settings(int floor_level, int ceiling_level, int tolerance_level);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FLOOR;
        i_cfg_data <= CFG_W'(floor_level);
        @(posedge i_clk);
        sb.write_register(CFG_FLOOR, CFG_W'(floor_level));
        i_cfg_index <= CFG_CEILING;
        i_cfg_data <= CFG_W'(ceiling_level);
        @(posedge i_clk);
        sb.write_register(CFG_CEILING, CFG_W'(ceiling_level));
        i_cfg_index <= CFG_TOLERANCE;
        i_cfg_data <= CFG_W'(tolerance_level);
        @(posedge i_clk);
        sb.write_register(CFG_TOLERANCE, CFG_W'(tolerance_level));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Levels spread over the full field, the register range and the special points.
    function automatic int pick_level();
        case ($urandom_range(0, 5))
            0: return int'($urandom);
            1: return -40000 + int'($urandom_range(0, 48000));
            2: return BREAKPOINTS[$urandom_range(0, 4)] + int'($urandom_range(0, 6)) - 3;
            3: return sb.floor_level + int'($urandom_range(0, 6)) - 3;
            4: return sb.ceiling_level + int'($urandom_range(0, 6)) - 3;
            default: return -23040 + int'($urandom_range(0, 25600));
        endcase
    endfunction

    function automatic int pick_travel();
        case ($urandom_range(0, 3))
            0: return int'($urandom);
            1: return int'($urandom_range(0, NORM_ONE + 4));
            default: return TRAVEL_POINTS[$urandom_range(0, 4)] + int'($urandom_range(0, 6)) - 3;
        endcase
    endfunction

    // Read-back levels near the commanded one, near the floor band, or anywhere.
    function automatic int pick_readback(int commanded);
        case ($urandom_range(0, 3))
            0, 1: return commanded + int'($urandom_range(0, 2 * sb.tolerance_level + 6))
                         - sb.tolerance_level - 3;
            2: return sb.floor_level + DB_ONE / 2 + int'($urandom_range(0, 6)) - 3;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic random_word();
        logic [1:0] op;
        logic [1:0] enc;
        int         pick;
        int         commanded;
        int         readback;
        pick = $urandom_range(0, 19);
        if (pick == 19) op = OP_RESERVED;
        else if (pick < 7) op = OP_ENCODE;
        else if (pick < 13) op = OP_DECODE;
        else op = OP_COMPARE;
        enc = ($urandom_range(0, 9) == 0) ? ENC_RESERVED : 2'($urandom_range(0, 2));
        if (op == OP_DECODE && (enc == ENC_NORM || enc == ENC_FLAG)) begin
            commanded = pick_travel();
        end else begin
            commanded = pick_level();
        end
        readback = (op == OP_COMPARE) ? pick_readback(commanded) : int'($urandom);
        send_word(op, enc, commanded, readback);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset settings: clamps, breakpoints and edge cases.
        send_word(OP_ENCODE, ENC_DB, 524287, 0);
        send_word(OP_ENCODE, ENC_DB, -524288, -1);
        send_word(OP_ENCODE, ENC_NORM, DB_M90, 0);
        send_word(OP_ENCODE, ENC_NORM, DB_M60, 0);
        send_word(OP_ENCODE, ENC_NORM, DB_M30, 0);
        send_word(OP_ENCODE, ENC_NORM, DB_M10, 0);
        send_word(OP_ENCODE, ENC_NORM, 10 * DB_ONE, 0);
        send_word(OP_ENCODE, ENC_NORM, -1, 0);
        send_word(OP_ENCODE, ENC_FLAG, -23040, 0);
        send_word(OP_ENCODE, ENC_FLAG, -23039, 0);
        send_word(OP_ENCODE, ENC_RESERVED, 1000, 0);
        send_word(OP_DECODE, ENC_DB, -524288, 0);
        send_word(OP_DECODE, ENC_NORM, 0, 0);
        send_word(OP_DECODE, ENC_NORM, -1, 0);
        send_word(OP_DECODE, ENC_NORM, NORM_ONE / 16, 0);
        send_word(OP_DECODE, ENC_NORM, NORM_ONE / 4, 0);
        send_word(OP_DECODE, ENC_NORM, NORM_ONE / 2, 0);
        send_word(OP_DECODE, ENC_NORM, NORM_ONE + 1, 0);
        send_word(OP_DECODE, ENC_NORM, 524287, 0);
        send_word(OP_DECODE, ENC_FLAG, 1, 0);
        send_word(OP_DECODE, ENC_FLAG, 0, 0);
        send_word(OP_COMPARE, ENC_DB, -28040, -23040 + DB_ONE / 2);
        send_word(OP_COMPARE, ENC_DB, -23040 + DB_ONE / 2 + 1, -23240);
        send_word(OP_COMPARE, ENC_DB, 1000, 1128);
        send_word(OP_COMPARE, ENC_DB, 1000, 871);
        send_word(OP_COMPARE, ENC_DB, 524287, -524288);
        send_word(OP_RESERVED, ENC_RESERVED, -524288, 524287);

        // Random phases, each under its own register settings.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;
                1: apply_settings(-36864, 5120, 2560);
                2: apply_settings(0, 0, 0);
                4: apply_settings(-36864, 0, 0);
                5: apply_settings(0, 5120, 2560);
                default: apply_settings(-int'($urandom_range(0, 36864)),
                                        $urandom_range(0, 5120), $urandom_range(0, 2560));
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) random_word();
            drain();
        end

        repeat (8) @(posedge i_clk);
        sb.close();
        if (sb.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/flc_pkg.sv
rtl/core/flc_db_to_norm.sv
rtl/core/flc_norm_to_db.sv
rtl/core/flc_compare.sv
rtl/core/fader_law_codec_top.sv
dv/tb_top.sv
